// ===== hw/rtl/swh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swh_pkg;

	// table depth and field widths
	localparam int MAX_COMPONENTS = 64;
	localparam int INDEX_BITS     = 20;
	localparam int VALUE_BITS     = 16;
	localparam int SUM_BITS       = 23;

	// stream packing
	localparam int IN_DATA_BITS  = 72;
	localparam int OUT_DATA_BITS = 72;
	localparam int OUT_USED_BITS = INDEX_BITS + 2 * SUM_BITS;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// word handed from cell to cell
	typedef struct packed {
		cmd_t                         cmd;
		logic                         done;
		logic [INDEX_BITS-1:0]        freq;
		logic signed [VALUE_BITS-1:0] coef_re;
		logic signed [VALUE_BITS-1:0] coef_im;
		logic [INDEX_BITS-1:0]        time_index;
		logic signed [SUM_BITS-1:0]   acc_re;
		logic signed [SUM_BITS-1:0]   acc_im;
	} word_t;

	// sign-extend a stored value to the sum width
	function automatic logic signed [SUM_BITS-1:0] widen(input logic signed [VALUE_BITS-1:0] v);
		widen = {{(SUM_BITS - VALUE_BITS){v[VALUE_BITS-1]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swh_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swh_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  swh_pkg::word_t       in_word,
	output logic                 out_valid,
	output swh_pkg::word_t       out_word
);
	import swh_pkg::*;

	logic                         occupied_q;
	logic [INDEX_BITS-1:0]        freq_q;
	logic signed [VALUE_BITS-1:0] re_q;
	logic signed [VALUE_BITS-1:0] im_q;
	logic                         valid_q;
	word_t                        word_q;

	logic  is_load;
	logic  hit;
	logic  fill;
	logic  clr;
	logic  flip;
	word_t nxt;

	// decide what this cell does with the passing word
	always_comb begin
		is_load = in_valid && (in_word.cmd == CMD_LOAD) && !in_word.done;
		hit     = is_load && occupied_q && (freq_q == in_word.freq);
		fill    = is_load && !occupied_q;
		clr     = in_valid && (in_word.cmd == CMD_CLEAR);
		flip    = ^(in_word.time_index & freq_q);
		nxt     = in_word;
		if (hit || fill) begin
			nxt.done = 1'b1;
		end
		if ((in_word.cmd == CMD_SAMPLE) && occupied_q) begin
			if (flip) begin
				nxt.acc_re = in_word.acc_re - widen(re_q);
				nxt.acc_im = in_word.acc_im - widen(im_q);
			end else begin
				nxt.acc_re = in_word.acc_re + widen(re_q);
				nxt.acc_im = in_word.acc_im + widen(im_q);
			end
		end
	end

	// control: occupancy and word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
			valid_q    <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
			if (clr) begin
				occupied_q <= 1'b0;
			end else if (fill) begin
				occupied_q <= 1'b1;
			end
		end
	end

	// payload: entry and passing word
	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
			if (hit || fill) begin
				freq_q <= in_word.freq;
				re_q   <= in_word.coef_re;
				im_q   <= in_word.coef_im;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_walsh_hadamard_synthesis.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sparse inverse Walsh-Hadamard synthesis over a table of up to 64 entries.
// Input stream s_*: tuser carries the command (clear, load entry, sample),
// tdata the frequency index, the Q1.15 coefficient pair and the time index.
// Output stream m_*: one word per sample command, carrying the echoed time
// index and the exact complex sum of +/- coefficient over all entries.
// The table lives in a row of 64 cells, one entry each; every word walks the
// row one cell per cycle unless the row holds, so loads, clears and samples
// act in arrival order. A sample word passes cell 0, the other 63 cells and
// then the output register before it shows on m_tvalid. The block accepts one
// word per cycle while the row is not held, the cell row advancing once per
// clock.
// Clear and load words produce no output and leave the row at its end.
// Reset empties the table and flushes the row; no clearing pass is needed.
// Stall: when a result waits in the output register and the next sample word
// has reached the end of the row, the whole row holds and s_tready drops;
// otherwise the row keeps moving while the result waits.
module sparse_walsh_hadamard_synthesis (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// freq_index[19:0], coef_re[35:20], coef_im[51:36], time_index[71:52]
	input  wire  [swh_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// cmd[1:0]
	input  wire  [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// sample_index[19:0], sum_re[42:20], sum_im[65:43], zero fill above
	output logic [swh_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
	import swh_pkg::*;

	logic  chain_valid [0:MAX_COMPONENTS];
	word_t chain_word  [0:MAX_COMPONENTS];

	logic  advance;
	logic  end_sample;
	logic  out_valid_q;
	word_t out_word_q;

	// build the entering word
	always_comb begin
		chain_valid[0]           = s_tvalid;
		chain_word[0].cmd        = cmd_t'(s_tuser);
		chain_word[0].done       = 1'b0;
		chain_word[0].freq       = s_tdata[INDEX_BITS-1:0];
		chain_word[0].coef_re    = s_tdata[INDEX_BITS +: VALUE_BITS];
		chain_word[0].coef_im    = s_tdata[INDEX_BITS + VALUE_BITS +: VALUE_BITS];
		chain_word[0].time_index = s_tdata[INDEX_BITS + 2 * VALUE_BITS +: INDEX_BITS];
		chain_word[0].acc_re     = '0;
		chain_word[0].acc_im     = '0;
	end

	// row of cells
	for (genvar i = 0; i < MAX_COMPONENTS; i++) begin : g_cell
		swh_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.in_valid  (chain_valid[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	// hold the row only when a finished sample cannot leave
	assign end_sample = chain_valid[MAX_COMPONENTS] &&
		(chain_word[MAX_COMPONENTS].cmd == CMD_SAMPLE);
	assign advance    = !(end_sample && out_valid_q && !m_tready);
	assign s_tready   = advance;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= end_sample;
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_valid_q || m_tready) && end_sample) begin
			out_word_q <= chain_word[MAX_COMPONENTS];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
		out_word_q.acc_im, out_word_q.acc_re, out_word_q.time_index};

endmodule

`default_nettype wire

// ===== hw/rtl/swh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swh_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire [swh_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input wire [1:0]                         s_tuser,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [swh_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
	import swh_pkg::*;

	// a stalled output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its contents
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	// input is refused only while an output word is held back
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// a refused input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input word changed while refused");

	// fill bits above the sums stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS] == '0))
		else $error("output fill bits not zero");

endmodule

bind sparse_walsh_hadamard_synthesis swh_checker u_swh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/tb_sparse_walsh_hadamard_synthesis.sv =====
`timescale 1ns / 1ps

module tb_sparse_walsh_hadamard_synthesis;

	import swh_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;

	// one expected sample word
	typedef struct {
		logic [INDEX_BITS-1:0] sample_index;
		logic [SUM_BITS-1:0]   sum_re;
		logic [SUM_BITS-1:0]   sum_im;
	} sample_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [1:0]               s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	// spectrum table as the block should hold it
	logic [INDEX_BITS-1:0]        spec_freq [MAX_COMPONENTS];
	logic signed [VALUE_BITS-1:0] spec_re   [MAX_COMPONENTS];
	logic signed [VALUE_BITS-1:0] spec_im   [MAX_COMPONENTS];
	int                           spec_count;

	sample_t               pending_samples [$];
	logic [INDEX_BITS-1:0] freq_pool [16];

	int n_fail;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	bit hold_req;
	int quiet_cycles;

	sparse_walsh_hadamard_synthesis DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// update the table and work out the sum for one accepted word
	task automatic apply_command(input cmd_t cmd, input logic [INDEX_BITS-1:0] freq,
			input logic signed [VALUE_BITS-1:0] re, input logic signed [VALUE_BITS-1:0] im,
			input logic [INDEX_BITS-1:0] t);
		int      acc_re;
		int      acc_im;
		bit      found;
		sample_t s;
		case (cmd)
			CMD_CLEAR: begin
				spec_count = 0;
			end
			CMD_LOAD: begin
				found = 1'b0;
				for (int i = 0; i < spec_count; i++) begin
					if (!found && spec_freq[i] == freq) begin
						spec_re[i] = re;
						spec_im[i] = im;
						found = 1'b1;
					end
				end
				// append, or drop when the table is full
				if (!found && spec_count < MAX_COMPONENTS) begin
					spec_freq[spec_count] = freq;
					spec_re[spec_count] = re;
					spec_im[spec_count] = im;
					spec_count++;
				end
			end
			CMD_SAMPLE: begin
				acc_re = 0;
				acc_im = 0;
				for (int i = 0; i < spec_count; i++) begin
					if (^(t & spec_freq[i])) begin
						acc_re -= int'(spec_re[i]);
						acc_im -= int'(spec_im[i]);
					end else begin
						acc_re += int'(spec_re[i]);
						acc_im += int'(spec_im[i]);
					end
				end
				s.sample_index = t;
				s.sum_re = acc_re[SUM_BITS-1:0];
				s.sum_im = acc_im[SUM_BITS-1:0];
				pending_samples.push_back(s);
			end
			default: ;
		endcase
	endtask

	// offer one word, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_word(input cmd_t cmd, input logic [INDEX_BITS-1:0] freq,
			input logic signed [VALUE_BITS-1:0] re, input logic signed [VALUE_BITS-1:0] im,
			input logic [INDEX_BITS-1:0] t);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {t, im, re, freq};
		do @(posedge clk); while (!s_tready);
		apply_command(cmd, freq, re, im, t);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// empty table gives zero
		send_word(CMD_SAMPLE, 20'h12345, 16'sh0, 16'sh0, 20'hABCDE);
		send_word(CMD_LOAD, 20'h00000, 16'sh7FFF, -16'sh8000, 20'h00000);
		send_word(CMD_LOAD, 20'hFFFFF, -16'sh8000, 16'sh7FFF, 20'hFFFFF);
		send_word(CMD_LOAD, 20'h00001, 16'sh0001, -16'sh0001, 20'h55555);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h00000);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'hFFFFF);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h00001);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'hAAAAA);
		// duplicate index replaces the value
		send_word(CMD_LOAD, 20'h00000, -16'sh8000, 16'sh7FFF, 20'hFFFFF);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h00000);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h80000);
		// unused command leaves the table as it is
		send_word(CMD_NONE, 20'hFFFFF, -16'sh1, -16'sh1, 20'hFFFFF);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h7FFFF);
		send_word(CMD_CLEAR, 20'hFFFFF, -16'sh1, -16'sh1, 20'hFFFFF);
		send_word(CMD_SAMPLE, 20'hFFFFF, -16'sh1, -16'sh1, 20'hFFFFF);
	endtask

	// fill the table to the brim with extreme values, then try past it
	task automatic test_table_full();
		logic [INDEX_BITS-1:0] f;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(CMD_CLEAR, 20'h0, 16'sh0, 16'sh0, 20'h0);
		for (int i = 0; i < MAX_COMPONENTS; i++) begin
			f = (i < 32) ? 20'(i * 32'h8421) : 20'($urandom);
			send_word(CMD_LOAD, f, -16'sh8000, 16'sh7FFF, 20'($urandom));
		end
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h00000);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'hFFFFF);
		send_word(CMD_LOAD, 20'hFFFFE, 16'sh7FFF, 16'sh7FFF, 20'h0);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'hFFFFE);
		send_word(CMD_LOAD, 20'h00000, 16'sh7FFF, -16'sh8000, 20'h0);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'h00000);
		send_word(CMD_SAMPLE, 20'h0, 16'sh0, 16'sh0, 20'($urandom));
	endtask

	// keep offering samples while the receiver holds off, so the row fills
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 8; i++)
			send_word(CMD_LOAD, 20'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
		hold_req = 1'b1;
		for (int i = 0; i < 200; i++)
			send_word(CMD_SAMPLE, 20'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		int                           sent;
		int                           roll;
		cmd_t                         cmd;
		logic [INDEX_BITS-1:0]        f;
		logic [INDEX_BITS-1:0]        t;
		logic signed [VALUE_BITS-1:0] re;
		logic signed [VALUE_BITS-1:0] im;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(0, 999);
			if (roll < 10)
				cmd = CMD_CLEAR;
			else if (roll < 30)
				cmd = CMD_NONE;
			else if (roll < 430)
				cmd = CMD_LOAD;
			else
				cmd = CMD_SAMPLE;
			// reuse a small pool of indices so that overwrites are common
			if ($urandom_range(0, 1))
				f = freq_pool[$urandom_range(0, 15)];
			else
				f = 20'($urandom);
			re = 16'($urandom);
			im = 16'($urandom);
			t = 20'($urandom);
			case ($urandom_range(0, 15))
				0: re = -16'sh8000;
				1: re = 16'sh7FFF;
				2: im = -16'sh8000;
				3: im = 16'sh7FFF;
				4: t = 20'h00000;
				5: t = 20'hFFFFF;
				default: ;
			endcase
			send_word(cmd, f, re, im, t);
			if (cmd != CMD_NONE)
				sent++;
		end
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// compare each accepted sample word with the oldest expectation
	always @(posedge clk) begin
		sample_t exp_s;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				n_fail++;
			end else begin
				exp_s = pending_samples.pop_front();
				if (m_tdata[19:0] !== exp_s.sample_index) begin
					$error("sample_index: expected %0h, got %0h", exp_s.sample_index,
						m_tdata[19:0]);
					n_fail++;
				end
				if (m_tdata[42:20] !== exp_s.sum_re) begin
					$error("sum_re: expected %0d, got %0d", $signed(exp_s.sum_re),
						$signed(m_tdata[42:20]));
					n_fail++;
				end
				if (m_tdata[65:43] !== exp_s.sum_im) begin
					$error("sum_im: expected %0d, got %0d", $signed(exp_s.sum_im),
						$signed(m_tdata[65:43]));
					n_fail++;
				end
				if (m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS] !== '0) begin
					$error("fill: expected 0, got %0h", m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS]);
					n_fail++;
				end
			end
		end
	end

	// abort when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("sparse_walsh_hadamard_synthesis verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = CMD_NONE;
		s_tdata = '0;
		m_tready = 1'b0;
		n_fail = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		spec_count = 0;
		for (int i = 0; i < 16; i++)
			freq_pool[i] = (i < 4) ? 20'(i) : 20'($urandom);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		test_backpressure();
		test_random(300, 0, 0);
		test_random(300, 85, 0);
		test_random(300, 0, 85);
		test_random(300, 29, 29);

		// drop valid, drain the row, then watch for stray words
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("sparse_walsh_hadamard_synthesis verification clean");
		else
			$display("sparse_walsh_hadamard_synthesis verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/swh_pkg.sv
hw/rtl/swh_cell.sv
hw/rtl/sparse_walsh_hadamard_synthesis.sv
hw/rtl/swh_checker.sv
test/tb_sparse_walsh_hadamard_synthesis.sv
